/* rtl/okvt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the ordered key-value table.
// Used by the channel interfaces, the controller, the datapath and the top level.

package okvt_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;
   localparam int MODE_BITS      = 3;
   localparam int STATUS_BITS    = 2;

   // Request modes. Codes 6 and 7 are unused and get a miss status.
   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT   = 3'd0,
      MODE_UPDATE   = 3'd1,
      MODE_UPSERT   = 3'd2,
      MODE_ERASE    = 3'd3,
      MODE_LOOKUP   = 3'd4,
      MODE_READ_POS = 3'd5
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_POS_READ,
      ST_POS_DATA,
      ST_REJECT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       req_ready;
      logic       load_req;
      logic       scan_step;
      logic       seek_next;
      logic       shift_write;
      logic       write_hit;
      logic       append;
      logic       count_dec;
      logic       pos_read;
      logic       set_result;
      status_type res_status;
      logic       res_key_rd;
      logic       res_value_rd;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                 in_valid;
      logic [MODE_BITS-1:0] in_mode;
      logic [MODE_BITS-1:0] mode;
      logic                 hit;
      logic                 sweep_end;
      logic                 full;
      logic                 pos_ok;
      logic                 out_free;
   } stat_type;

endpackage

/* rtl/okvt_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the ordered key-value table.
// Depends on okvt_pkg for the mode and status widths.

interface okvt_req_if
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
);
   localparam int POS_BITS = $clog2(CAPACITY);

   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;
   logic [POS_BITS-1:0]   position;

   modport source (output valid, mode, key, value, position, input ready);
   modport sink   (input valid, mode, key, value, position, output ready);
endinterface

interface okvt_rsp_if
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0]    key_out;
   logic [VALUE_BITS-1:0]  value_out;
   logic [CNT_BITS-1:0]    entry_count;

   modport source (output valid, status, key_out, value_out, entry_count, input ready);
   modport sink   (input valid, status, key_out, value_out, entry_count, output ready);
endinterface

/* rtl/okvt_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the ordered key-value table.
// Depends on okvt_pkg; drives the datapath through cmd_type and reads stat_type.

module okvt_ctrl
   import okvt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   mode_type  in_mode, cur_mode;
   logic      in_find, in_pos;

   assign in_mode  = mode_type'(stat.in_mode);
   assign cur_mode = mode_type'(stat.mode);
   assign in_find  = (in_mode == MODE_INSERT) || (in_mode == MODE_UPDATE) ||
                     (in_mode == MODE_UPSERT) || (in_mode == MODE_ERASE) ||
                     (in_mode == MODE_LOOKUP);
   assign in_pos   = (in_mode == MODE_READ_POS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.in_valid) begin
               priority if (in_find) begin
                  state_in = ST_SCAN;
               end else if (in_pos) begin
                  state_in = ST_POS_READ;
               end else begin
                  state_in = ST_REJECT;
               end
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = (cur_mode == MODE_ERASE) ? ST_SHIFT : ST_DONE;
            end else if (stat.sweep_end) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (stat.sweep_end) begin
               state_in = ST_DONE;
            end
         end
         ST_POS_READ: state_in = ST_POS_DATA;
         ST_POS_DATA: state_in = ST_DONE;
         ST_REJECT:   state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd            = '0;
      cmd.res_status = STATUS_MISS;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.load_req  = stat.in_valid;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.set_result = 1'b1;
               unique case (cur_mode)
                  MODE_UPDATE, MODE_UPSERT: begin
                     cmd.write_hit  = 1'b1;
                     cmd.res_status = STATUS_OK;
                  end
                  MODE_ERASE: begin
                     cmd.set_result = 1'b0;
                     cmd.seek_next  = 1'b1;
                  end
                  MODE_LOOKUP: begin
                     cmd.res_status   = STATUS_OK;
                     cmd.res_value_rd = 1'b1;
                  end
                  default: cmd.res_status = STATUS_MISS;
               endcase
            end else if (stat.sweep_end) begin
               cmd.set_result = 1'b1;
               if ((cur_mode == MODE_INSERT) || (cur_mode == MODE_UPSERT)) begin
                  if (stat.full) begin
                     cmd.res_status = STATUS_FULL;
                  end else begin
                     cmd.append     = 1'b1;
                     cmd.res_status = STATUS_OK;
                  end
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.shift_write = 1'b1;
            if (stat.sweep_end) begin
               cmd.count_dec  = 1'b1;
               cmd.set_result = 1'b1;
               cmd.res_status = STATUS_OK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_POS_READ: cmd.pos_read = 1'b1;
         ST_POS_DATA: begin
            cmd.set_result = 1'b1;
            if (stat.pos_ok) begin
               cmd.res_status   = STATUS_OK;
               cmd.res_key_rd   = 1'b1;
               cmd.res_value_rd = 1'b1;
            end
         end
         ST_REJECT: cmd.set_result = 1'b1;
         ST_DONE:   cmd.load_rsp   = stat.out_free;
         default:   cmd.req_ready  = 1'b0;
      endcase
   end

endmodule

/* rtl/okvt_dp.sv */
`timescale 1ns / 1ps
// Datapath of the ordered key-value table: key and value memories, entry count,
// scan pointer, request and result registers. Depends on okvt_pkg and okvt_if.

module okvt_dp
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
   input  logic     clock,
   input  logic     reset,
   okvt_req_if.sink   req_in,
   okvt_rsp_if.source rsp_out,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = $clog2(CAPACITY + 2);

   logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
   logic [VALUE_BITS-1:0] value_mem [CAPACITY];

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  live_ff, live_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;

   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]         pos_ff, pos_in;

   status_type            res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  wr_key_en, wr_value_en;
   logic [KEY_BITS-1:0]   wr_key_data;
   logic [VALUE_BITS-1:0] wr_value_data;
   logic                  out_free;

   // Memory ports: one read address, one write address per cycle.
   assign rd_addr       = cmd.pos_read ? pos_ff : idx_ff[AW-1:0];
   assign wr_key_en     = cmd.append | (cmd.shift_write & live_ff);
   assign wr_value_en   = wr_key_en | cmd.write_hit;
   assign wr_key_data   = cmd.append ? key_ff : key_rd_ff;
   assign wr_value_data = (cmd.append | cmd.write_hit) ? value_ff : value_rd_ff;

   always_comb begin
      priority if (cmd.append) begin
         wr_addr = count_ff[AW-1:0];
      end else if (cmd.write_hit) begin
         wr_addr = addr_ff;
      end else begin
         // Erase compaction moves the entry just read one place down.
         wr_addr = addr_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key_data;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_value_en) begin
         value_mem[wr_addr] <= wr_value_data;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   // Scan pointer, liveness of the entry in the read register, entry count.
   always_comb begin
      idx_in   = idx_ff;
      live_in  = live_ff;
      addr_in  = addr_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         idx_in  = '0;
         live_in = 1'b0;
      end else if (cmd.seek_next) begin
         idx_in  = IDX_BITS'(addr_ff) + IDX_BITS'(1);
         live_in = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in  = idx_ff + IDX_BITS'(1);
         live_in = idx_ff < IDX_BITS'(count_ff);
         addr_in = idx_ff[AW-1:0];
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      mode_in  = cmd.load_req ? req_in.mode     : mode_ff;
      key_in   = cmd.load_req ? req_in.key      : key_ff;
      value_in = cmd.load_req ? req_in.value    : value_ff;
      pos_in   = cmd.load_req ? req_in.position : pos_ff;
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_value_in  = res_value_ff;
      if (cmd.set_result) begin
         res_status_in = cmd.res_status;
         res_key_in    = cmd.res_key_rd ? key_rd_ff : key_ff;
         res_value_in  = cmd.res_value_rd ? value_rd_ff : '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_out.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_key_in    = res_key_ff;
         rsp_value_in  = res_value_ff;
         rsp_count_in  = count_ff;
      end else if (rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_in.ready        = cmd.req_ready;
   assign rsp_out.valid       = rsp_valid_ff;
   assign rsp_out.status      = rsp_status_ff;
   assign rsp_out.key_out     = rsp_key_ff;
   assign rsp_out.value_out   = rsp_value_ff;
   assign rsp_out.entry_count = rsp_count_ff;

   assign stat.in_valid  = req_in.valid;
   assign stat.in_mode   = req_in.mode;
   assign stat.mode      = mode_ff;
   assign stat.hit       = live_ff && (key_rd_ff == key_ff);
   assign stat.sweep_end = !live_ff && (idx_ff >= IDX_BITS'(count_ff));
   assign stat.full      = count_ff >= CNT_BITS'(CAPACITY);
   assign stat.pos_ok    = CNT_BITS'(pos_ff) < count_ff;
   assign stat.out_free  = out_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (count_ff < CNT_BITS'(CAPACITY)))
      else $error("append into a full table");

   a_erase_count: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("erase did not lower the entry count by one");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift_write && live_ff) |-> (addr_ff != '0))
      else $error("compaction write below the first entry");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_out.ready))
      else $error("response overwritten before it was taken");

endmodule

/* rtl/ordered_key_value_table_top.sv */
`timescale 1ns / 1ps
// Top level of the ordered key-value table: controller plus datapath.
// Depends on okvt_pkg, okvt_if, okvt_ctrl and okvt_dp.
//
// Usage: requests arrive on req_in (mode, key, value, position) and one result
// item per request leaves on rsp_out (status, key_out, value_out, entry_count).
// Both channels move an item at a rising clock edge where valid and ready are high.
// The block works on one request at a time; req_in.ready is high only while idle.
// Key searches walk the key memory one entry per cycle through its single read
// port, from the first entry on, until the key is found or every stored entry
// has been seen; on an empty table the search has nothing to walk and misses.
// Erase then compacts the later entries at one per cycle, moving each one place
// down, and lowers the count. A read by position reads the given place and gives
// a miss when it lies at or above the count; an unused mode gets a miss. The
// controller returns to idle after each result before it takes the next request.
// The result sits in an output register, so the next request is accepted while a
// result still waits; when the receiver stalls, a finished result is held in the
// controller's final state until the output register frees up.
// A synchronous reset empties the table (count zero) and drops any pending result;
// the memories themselves are not cleared, entries above the count are never read.

module ordered_key_value_table_top
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
   input logic        clock,
   input logic        reset,
   okvt_req_if.sink   req_in,
   okvt_rsp_if.source rsp_out
);

   // Command and status groups between the two halves.
   cmd_type  cmd;
   stat_type stat;

   // The controller sequences search, compaction, position reads and result hand-off.
   okvt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the memories, the entry count and all payload registers.
   okvt_dp #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_in),
      .rsp_out (rsp_out),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule
